FILE: rtl/hat_pkg.sv
// Shared types, codes and constants of the hysteresis alarm table.
package hat_pkg;

    // Table geometry
    localparam int CHANNELS = 16;
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Item actions
    localparam logic [1:0] ACT_SAMPLE = 2'd0;
    localparam logic [1:0] ACT_SET    = 2'd1;
    localparam logic [1:0] ACT_FORGET = 2'd2;
    localparam logic [1:0] ACT_QUERY  = 2'd3;

    // Alarm states
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_LOW  = 2'd1;
    localparam logic [1:0] ST_HIGH = 2'd2;

    // Rule flag bits
    localparam int FL_LO     = 0;
    localparam int FL_HI     = 1;
    localparam int FL_REMOTE = 2;

    // Configuration register indexes and reset values
    localparam int          CFG_IDX_W           = 1;
    localparam logic [0:0]  CFG_REPEAT_INTERVAL = 1'd0;
    localparam logic [0:0]  CFG_DEBOUNCE_COUNT  = 1'd1;
    localparam logic [31:0] REPEAT_RESET        = 32'd1800000000;
    localparam logic [3:0]  DEBOUNCE_RESET      = 4'd2;

    // Default hysteresis of a freshly opened channel: 1.0 in Q23.8
    localparam logic [30:0] DEFAULT_HYST = 31'd256;
    localparam logic [3:0]  COUNT_MAX    = 4'd15;

    // One channel entry of the table
    typedef struct packed {
        logic signed [31:0] low;
        logic signed [31:0] high;
        logic [30:0]        hyst;
        logic [2:0]         flags;
        logic [1:0]         cur;
        logic [1:0]         pend;
        logic [3:0]         cnt;
        logic [63:0]        last_time;
        logic signed [31:0] last_value;
        logic               has_value;
    } entry_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_item;
        logic read_entry;
        logic commit;
    } hat_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_valid;
    } hat_status_t;

endpackage

FILE: rtl/hysteresis_alarm_table_top.sv
// Top level of the hysteresis alarm table: controller and datapath.
//
// Usage: each input transaction (s_valid/s_ready) carries an action on one
// channel: sample, set rule, forget or query. Every transaction yields exactly
// one result transaction (m_valid/m_ready) with the notification flags, the
// channel, the states before and after, and the reported value.
// Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) set the
// repeat interval (index 0) and the debounce count (index 1); cfg_ready is
// always high. Write configuration only while the block is idle.
// Each transaction passes the read stage (channel entry read from the table),
// then the evaluate-and-commit stage (entry written back, result registered).
// No new transaction is accepted while one is in the read stage.
// A finished result sits in an output register; the next transaction is
// accepted and read meanwhile. If the receiver stalls, the commit stage holds
// until the output register frees, and s_ready stays low until then.
// Reset (aresetn low, synchronous) marks every channel unused and restores
// the configuration defaults; no clearing pass is needed.
module hysteresis_alarm_table_top import hat_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_action,
    input  logic [3:0]           s_channel,
    input  logic signed [31:0]   s_sample_value,
    input  logic [63:0]          s_now_us,
    input  logic signed [31:0]   s_low_limit,
    input  logic signed [31:0]   s_high_limit,
    input  logic [30:0]          s_hysteresis,
    input  logic                 s_low_enable,
    input  logic                 s_high_enable,
    input  logic                 s_remote_low,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_notify,
    output logic                 m_is_reminder,
    output logic [3:0]           m_out_channel,
    output logic [1:0]           m_from_state,
    output logic [1:0]           m_alarm_state,
    output logic signed [31:0]   m_report_value
);

    hat_cmd_t    cmd;
    hat_status_t status;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    hat_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    hat_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_action       (s_action),
        .s_channel      (s_channel),
        .s_sample_value (s_sample_value),
        .s_now_us       (s_now_us),
        .s_low_limit    (s_low_limit),
        .s_high_limit   (s_high_limit),
        .s_hysteresis   (s_hysteresis),
        .s_low_enable   (s_low_enable),
        .s_high_enable  (s_high_enable),
        .s_remote_low   (s_remote_low),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_notify       (m_notify),
        .m_is_reminder  (m_is_reminder),
        .m_out_channel  (m_out_channel),
        .m_from_state   (m_from_state),
        .m_alarm_state  (m_alarm_state),
        .m_report_value (m_report_value)
    );

endmodule

FILE: rtl/hat_ctrl.sv
// Sequencing controller: accept, table read, evaluate and commit.
module hat_ctrl import hat_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        m_ready,
    input  hat_status_t status,
    output hat_cmd_t    cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_WRITE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_free;
    logic       accept;

    // Output slot frees when empty or being taken this cycle
    assign out_free = !status.out_valid || m_ready;
    assign s_ready  = (state_reg == S_IDLE) || ((state_reg == S_WRITE) && out_free);
    assign accept   = s_valid && s_ready;

    // Drive datapath commands
    always_comb begin
        cmd.load_item  = accept;
        cmd.read_entry = (state_reg == S_READ);
        cmd.commit     = (state_reg == S_WRITE) && out_free;
    end

    // Advance the sequence
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) state_next = S_READ;
            end
            S_READ: begin
                state_next = S_WRITE;
            end
            S_WRITE: begin
                if (out_free) state_next = accept ? S_READ : S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/hat_dp.sv
// Datapath: channel table, configuration registers, evaluation and result register.
module hat_dp import hat_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  hat_cmd_t             cmd,
    output hat_status_t          status,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic [1:0]           s_action,
    input  logic [3:0]           s_channel,
    input  logic signed [31:0]   s_sample_value,
    input  logic [63:0]          s_now_us,
    input  logic signed [31:0]   s_low_limit,
    input  logic signed [31:0]   s_high_limit,
    input  logic [30:0]          s_hysteresis,
    input  logic                 s_low_enable,
    input  logic                 s_high_enable,
    input  logic                 s_remote_low,
    input  logic                 m_ready,
    output logic                 m_valid,
    output logic                 m_notify,
    output logic                 m_is_reminder,
    output logic [3:0]           m_out_channel,
    output logic [1:0]           m_from_state,
    output logic [1:0]           m_alarm_state,
    output logic signed [31:0]   m_report_value
);

    // Configuration
    logic [31:0] repeat_interval_reg;
    logic [3:0]  debounce_count_reg;

    // Held transaction
    logic [1:0]         action_reg;
    logic [3:0]         channel_reg;
    logic signed [31:0] sample_reg;
    logic [63:0]        now_reg;
    logic signed [31:0] low_in_reg;
    logic signed [31:0] high_in_reg;
    logic [30:0]        hyst_in_reg;
    logic [2:0]         flags_in_reg;

    // Table
    entry_t              entry_mem [CHANNELS];
    logic [CHANNELS-1:0] in_use_reg;

    // Read stage
    entry_t             ent_reg;
    logic               in_range_reg;
    logic signed [32:0] lo_up_reg;
    logic signed [32:0] hi_dn_reg;
    logic [63:0]        elapsed_reg;

    // Evaluation
    logic [CH_IDX_W-1:0] idx;
    logic                in_range;
    entry_t              ent_rd;
    entry_t              ent_new;
    logic                we;
    logic                use_new;
    logic [1:0]          want;
    logic [1:0]          want_set;
    logic [3:0]          need;
    logic [3:0]          cnt_new;
    logic signed [32:0]  x;
    logic                notify_c;
    logic                rem_c;
    logic [1:0]          from_c;
    logic [1:0]          to_c;
    logic signed [31:0]  rep_c;

    // Result register
    logic               m_valid_reg;
    logic               notify_reg;
    logic               rem_reg;
    logic [3:0]         ochan_reg;
    logic [1:0]         from_reg;
    logic [1:0]         to_reg;
    logic signed [31:0] rep_reg;

    function automatic logic is_muted(input logic [2:0] flags, input logic [1:0] from_st,
                                      input logic [1:0] to_st);
        return flags[FL_REMOTE] && ((from_st == ST_LOW) || (to_st == ST_LOW));
    endfunction

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            repeat_interval_reg <= REPEAT_RESET;
            debounce_count_reg  <= DEBOUNCE_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_REPEAT_INTERVAL: repeat_interval_reg <= cfg_data;
                CFG_DEBOUNCE_COUNT:  debounce_count_reg  <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Hold the accepted transaction
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            action_reg   <= s_action;
            channel_reg  <= s_channel;
            sample_reg   <= s_sample_value;
            now_reg      <= s_now_us;
            low_in_reg   <= s_low_limit;
            high_in_reg  <= s_high_limit;
            hyst_in_reg  <= s_hysteresis;
            flags_in_reg <= {s_remote_low, s_high_enable, s_low_enable};
        end
    end

    assign idx      = CH_IDX_W'(channel_reg);
    assign in_range = (32'(channel_reg) < CHANNELS);

    // An unused channel reads as freshly opened with the default rule
    always_comb begin
        if (in_use_reg[idx]) begin
            ent_rd = entry_mem[idx];
        end else begin
            ent_rd      = '0;
            ent_rd.hyst = DEFAULT_HYST;
        end
    end

    // Read the entry and precompute bounds and elapsed time
    always_ff @(posedge aclk) begin
        if (cmd.read_entry) begin
            ent_reg      <= ent_rd;
            in_range_reg <= in_range;
            lo_up_reg    <= {ent_rd.low[31], ent_rd.low} + {2'b00, ent_rd.hyst};
            hi_dn_reg    <= {ent_rd.high[31], ent_rd.high} - {2'b00, ent_rd.hyst};
            elapsed_reg  <= now_reg - ent_rd.last_time;
        end
    end

    assign x    = {sample_reg[31], sample_reg};
    assign need = (debounce_count_reg == 4'd0) ? 4'd1 : debounce_count_reg;

    // Find the state a sample asks for, starting from the current state
    always_comb begin
        unique case (ent_reg.cur)
            ST_LOW:  want = (!ent_reg.flags[FL_LO] || x >= lo_up_reg) ? ST_OK : ST_LOW;
            ST_HIGH: want = (!ent_reg.flags[FL_HI] || x <= hi_dn_reg) ? ST_OK : ST_HIGH;
            default: begin
                if (ent_reg.flags[FL_LO] && (sample_reg < ent_reg.low)) want = ST_LOW;
                else if (ent_reg.flags[FL_HI] && (sample_reg > ent_reg.high)) want = ST_HIGH;
                else want = ST_OK;
            end
        endcase
    end

    // Re-evaluate the last value against a new rule, from OK
    always_comb begin
        if (flags_in_reg[FL_LO] && (ent_reg.last_value < low_in_reg)) want_set = ST_LOW;
        else if (flags_in_reg[FL_HI] && (ent_reg.last_value > high_in_reg)) want_set = ST_HIGH;
        else want_set = ST_OK;
    end

    // Debounce counter update
    always_comb begin
        if (want == ent_reg.pend) begin
            cnt_new = (ent_reg.cnt == COUNT_MAX) ? COUNT_MAX : ent_reg.cnt + 4'd1;
        end else begin
            cnt_new = 4'd1;
        end
    end

    // Evaluate the transaction and build the new entry and result
    always_comb begin
        ent_new  = ent_reg;
        we       = 1'b0;
        use_new  = 1'b1;
        notify_c = 1'b0;
        rem_c    = 1'b0;
        from_c   = ST_OK;
        to_c     = ST_OK;
        rep_c    = '0;
        if (in_range_reg) begin
            unique case (action_reg)
                ACT_SAMPLE: begin
                    we                 = 1'b1;
                    ent_new.last_value = sample_reg;
                    ent_new.has_value  = 1'b1;
                    rep_c              = sample_reg;
                    from_c             = ent_reg.cur;
                    to_c               = ent_reg.cur;
                    if (want != ent_reg.cur) begin
                        ent_new.pend = want;
                        ent_new.cnt  = cnt_new;
                        if (cnt_new >= need) begin
                            ent_new.cur       = want;
                            ent_new.cnt       = 4'd0;
                            ent_new.last_time = now_reg;
                            to_c              = want;
                            notify_c          = !is_muted(ent_reg.flags, ent_reg.cur, want);
                        end
                    end else begin
                        ent_new.pend = ent_reg.cur;
                        ent_new.cnt  = 4'd0;
                        if ((ent_reg.cur != ST_OK) &&
                            (elapsed_reg >= {32'd0, repeat_interval_reg})) begin
                            ent_new.last_time = now_reg;
                            if (!is_muted(ent_reg.flags, ent_reg.cur, ent_reg.cur)) begin
                                notify_c = 1'b1;
                                rem_c    = 1'b1;
                            end
                        end
                    end
                end
                ACT_SET: begin
                    we            = 1'b1;
                    from_c        = ent_reg.cur;
                    ent_new.low   = low_in_reg;
                    ent_new.high  = high_in_reg;
                    ent_new.hyst  = hyst_in_reg;
                    ent_new.flags = flags_in_reg;
                    ent_new.cur   = ST_OK;
                    ent_new.pend  = ST_OK;
                    ent_new.cnt   = 4'd0;
                    if (ent_reg.has_value) begin
                        rep_c = ent_reg.last_value;
                        if (want_set != ST_OK) begin
                            ent_new.cur       = want_set;
                            ent_new.last_time = now_reg;
                            notify_c          = !is_muted(flags_in_reg, ST_OK, want_set);
                        end
                    end
                    to_c = ent_new.cur;
                end
                ACT_FORGET: begin
                    we      = 1'b1;
                    use_new = 1'b0;
                    from_c  = ent_reg.cur;
                end
                ACT_QUERY: begin
                    from_c = ent_reg.cur;
                    to_c   = ent_reg.cur;
                    rep_c  = ent_reg.has_value ? ent_reg.last_value : 32'sd0;
                end
                default: ;
            endcase
        end
    end

    // Write back the channel entry
    always_ff @(posedge aclk) begin
        if (cmd.commit && we) begin
            entry_mem[idx] <= ent_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_use_reg <= '0;
        end else if (cmd.commit && we) begin
            in_use_reg[idx] <= use_new;
        end
    end

    // Load the result register; drop valid once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            notify_reg <= notify_c;
            rem_reg    <= rem_c;
            ochan_reg  <= channel_reg;
            from_reg   <= from_c;
            to_reg     <= to_c;
            rep_reg    <= rep_c;
        end
    end

    assign status.out_valid = m_valid_reg;
    assign m_valid          = m_valid_reg;
    assign m_notify         = notify_reg;
    assign m_is_reminder    = rem_reg;
    assign m_out_channel    = ochan_reg;
    assign m_from_state     = from_reg;
    assign m_alarm_state    = to_reg;
    assign m_report_value   = rep_reg;

endmodule

FILE: sim/tb.sv
// Self-checking testbench of the hysteresis alarm table: directed and random transactions.
module tb import hat_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [1:0]         action;
        logic [3:0]         channel;
        logic signed [31:0] sample;
        logic [63:0]        now;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic [30:0]        hyst;
        logic               lo_en;
        logic               hi_en;
        logic               remote;
    } alarm_item_t;

    typedef struct {
        logic               notify;
        logic               reminder;
        logic [3:0]         chan;
        logic [1:0]         from_st;
        logic [1:0]         to_st;
        logic signed [31:0] value;
    } alarm_result_t;

    // Alarm table mirror: tracks every channel and queues the outcome of each transaction
    class alarm_scoreboard;
        logic [31:0]   repeat_interval;
        logic [3:0]    debounce;
        bit            used [CHANNELS];
        entry_t        entries [CHANNELS];
        alarm_result_t alarm_q [$];
        int            errors;

        function new();
            int c;
            repeat_interval = REPEAT_RESET;
            debounce = DEBOUNCE_RESET;
            errors = 0;
            for (c = 0; c < CHANNELS; c++) begin
                clear_entry(c);
            end
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
            if (idx == CFG_REPEAT_INTERVAL) begin
                repeat_interval = data;
            end else begin
                debounce = data[3:0];
            end
        endfunction

        function void clear_entry(int c);
            used[c] = 1'b0;
            entries[c] = '0;
        endfunction

        // Open an unused channel with the default rule: limits off, hysteresis 1.0
        function void open_entry(int c);
            if (!used[c]) begin
                clear_entry(c);
                entries[c].hyst = DEFAULT_HYST;
                used[c] = 1'b1;
            end
        endfunction

        // State the value asks for, with hysteresis on the way back to OK
        function logic [1:0] wanted_state(int c, logic [1:0] st, logic signed [31:0] v);
            longint x;
            longint lo;
            longint hi;
            longint h;
            bit     lo_on;
            bit     hi_on;
            x = v;
            lo = $signed(entries[c].low);
            hi = $signed(entries[c].high);
            h = longint'(entries[c].hyst);
            lo_on = entries[c].flags[FL_LO];
            hi_on = entries[c].flags[FL_HI];
            if (st == ST_LOW) begin
                return (!lo_on || x >= lo + h) ? ST_OK : ST_LOW;
            end
            if (st == ST_HIGH) begin
                return (!hi_on || x <= hi - h) ? ST_OK : ST_HIGH;
            end
            if (lo_on && x < lo) begin
                return ST_LOW;
            end
            if (hi_on && x > hi) begin
                return ST_HIGH;
            end
            return ST_OK;
        endfunction

        function bit muted(int c, logic [1:0] from_st, logic [1:0] to_st);
            return entries[c].flags[FL_REMOTE] && (from_st == ST_LOW || to_st == ST_LOW);
        endfunction

        // Apply one accepted transaction to the mirror and queue its outcome
        function void predict_alarm(alarm_item_t it);
            alarm_result_t r;
            logic [1:0]    st;
            logic [1:0]    goal;
            logic [3:0]    need;
            int            c;
            c = it.channel;
            r.notify = 1'b0;
            r.reminder = 1'b0;
            r.chan = it.channel;
            r.from_st = ST_OK;
            r.to_st = ST_OK;
            r.value = '0;
            case (it.action)
                ACT_SAMPLE: begin
                    open_entry(c);
                    entries[c].last_value = it.sample;
                    entries[c].has_value = 1'b1;
                    r.value = it.sample;
                    st = entries[c].cur;
                    r.from_st = st;
                    r.to_st = st;
                    goal = wanted_state(c, st, it.sample);
                    need = (debounce == 4'd0) ? 4'd1 : debounce;
                    if (goal != st) begin
                        // count agreeing samples toward the new state
                        if (goal == entries[c].pend) begin
                            if (entries[c].cnt < COUNT_MAX) begin
                                entries[c].cnt = entries[c].cnt + 4'd1;
                            end
                        end else begin
                            entries[c].pend = goal;
                            entries[c].cnt = 4'd1;
                        end
                        if (entries[c].cnt >= need) begin
                            entries[c].cur = goal;
                            entries[c].cnt = 4'd0;
                            entries[c].last_time = it.now;
                            r.to_st = goal;
                            r.notify = !muted(c, st, goal);
                        end
                    end else begin
                        entries[c].pend = st;
                        entries[c].cnt = 4'd0;
                        // remind while out of range; time difference wraps
                        if (st != ST_OK &&
                            (it.now - entries[c].last_time) >= {32'd0, repeat_interval}) begin
                            entries[c].last_time = it.now;
                            if (!muted(c, st, st)) begin
                                r.notify = 1'b1;
                                r.reminder = 1'b1;
                            end
                        end
                    end
                end
                ACT_SET: begin
                    open_entry(c);
                    r.from_st = entries[c].cur;
                    entries[c].low = it.lo;
                    entries[c].high = it.hi;
                    entries[c].hyst = it.hyst;
                    entries[c].flags[FL_LO] = it.lo_en;
                    entries[c].flags[FL_HI] = it.hi_en;
                    entries[c].flags[FL_REMOTE] = it.remote;
                    entries[c].cur = ST_OK;
                    entries[c].pend = ST_OK;
                    entries[c].cnt = 4'd0;
                    // re-evaluate the last value at once, no debounce
                    if (entries[c].has_value) begin
                        goal = wanted_state(c, ST_OK, entries[c].last_value);
                        r.value = entries[c].last_value;
                        if (goal != ST_OK) begin
                            entries[c].cur = goal;
                            entries[c].last_time = it.now;
                            r.notify = !muted(c, ST_OK, goal);
                        end
                    end
                    r.to_st = entries[c].cur;
                end
                ACT_FORGET: begin
                    if (used[c]) begin
                        r.from_st = entries[c].cur;
                        clear_entry(c);
                    end
                end
                ACT_QUERY: begin
                    if (used[c]) begin
                        r.from_st = entries[c].cur;
                        r.to_st = entries[c].cur;
                        if (entries[c].has_value) begin
                            r.value = entries[c].last_value;
                        end
                    end
                end
            endcase
            alarm_q.push_back(r);
        endfunction

        function void report_field(string field, logic [63:0] exp_v, logic [63:0] act_v);
            errors++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, exp_v, act_v);
        endfunction

        // Compare one accepted result with the oldest outcome waiting
        function void check_alarm(alarm_result_t got);
            alarm_result_t want;
            if (alarm_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, actual channel %0d value %0h",
                         $time, got.chan, got.value);
                return;
            end
            want = alarm_q.pop_front();
            if (got.notify !== want.notify) report_field("notify", want.notify, got.notify);
            if (got.reminder !== want.reminder) begin
                report_field("is_reminder", want.reminder, got.reminder);
            end
            if (got.chan !== want.chan) report_field("out_channel", want.chan, got.chan);
            if (got.from_st !== want.from_st) begin
                report_field("from_state", want.from_st, got.from_st);
            end
            if (got.to_st !== want.to_st) report_field("alarm_state", want.to_st, got.to_st);
            if (got.value !== want.value) report_field("report_value", want.value, got.value);
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    logic [1:0]           s_action;
    logic [3:0]           s_channel;
    logic signed [31:0]   s_sample_value;
    logic [63:0]          s_now_us;
    logic signed [31:0]   s_low_limit;
    logic signed [31:0]   s_high_limit;
    logic [30:0]          s_hysteresis;
    logic                 s_low_enable;
    logic                 s_high_enable;
    logic                 s_remote_low;
    logic                 m_valid;
    logic                 m_ready;
    logic                 m_notify;
    logic                 m_is_reminder;
    logic [3:0]           m_out_channel;
    logic [1:0]           m_from_state;
    logic [1:0]           m_alarm_state;
    logic signed [31:0]   m_report_value;

    alarm_scoreboard sb = new();

    bit          calm;
    bit          hold_off_req;
    logic [63:0] wall_us;
    int          focus [4];
    int          region [CHANNELS];

    hysteresis_alarm_table_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_channel      (s_channel),
        .s_sample_value (s_sample_value),
        .s_now_us       (s_now_us),
        .s_low_limit    (s_low_limit),
        .s_high_limit   (s_high_limit),
        .s_hysteresis   (s_hysteresis),
        .s_low_enable   (s_low_enable),
        .s_high_enable  (s_high_enable),
        .s_remote_low   (s_remote_low),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_notify       (m_notify),
        .m_is_reminder  (m_is_reminder),
        .m_out_channel  (m_out_channel),
        .m_from_state   (m_from_state),
        .m_alarm_state  (m_alarm_state),
        .m_report_value (m_report_value)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Build a transaction with the rule fields cleared
    function automatic alarm_item_t plain_item(logic [1:0] act, logic [3:0] ch,
                                               logic signed [31:0] v, logic [63:0] t);
        alarm_item_t it;
        it = '{default: 0};
        it.action = act;
        it.channel = ch;
        it.sample = v;
        it.now = t;
        return it;
    endfunction

    function automatic alarm_item_t rule_item(logic [3:0] ch, logic signed [31:0] lo,
                                              logic signed [31:0] hi, logic [30:0] hyst,
                                              logic le, logic he, logic rl, logic [63:0] t);
        alarm_item_t it;
        it = plain_item(ACT_SET, ch, 32'sd0, t);
        it.lo = lo;
        it.hi = hi;
        it.hyst = hyst;
        it.lo_en = le;
        it.hi_en = he;
        it.remote = rl;
        return it;
    endfunction

    // Advance the running clock: mostly small steps, sometimes big jumps or going back
    function automatic void advance_wall();
        int k;
        k = $urandom_range(0, 99);
        if (k < 3) begin
            wall_us = wall_us - 64'($urandom_range(0, 1000));
        end else if (k < 7) begin
            wall_us = wall_us + {31'd0, 1'($urandom_range(0, 1)), 32'($urandom)};
        end else begin
            wall_us = wall_us + 64'($urandom_range(0, 200));
        end
    endfunction

    // Draw a sample near the channel's limits so the alarm states get exercised
    function automatic logic signed [31:0] pick_sample(int c);
        int lo;
        int hi;
        int hy;
        int v;
        lo = sb.entries[c].low;
        hi = sb.entries[c].high;
        hy = int'(sb.entries[c].hyst);
        // hold a channel in one region for a while so debounce can confirm
        if ($urandom_range(0, 7) == 0) region[c] = $urandom_range(0, 4);
        case (region[c])
            0: v = lo - int'($urandom_range(1, 300));
            1: v = lo + (hi - lo) / 2;
            2: v = hi + int'($urandom_range(1, 300));
            3: begin
                case ($urandom_range(0, 7))
                    0: v = lo - 1;
                    1: v = lo;
                    2: v = lo + hy - 1;
                    3: v = lo + hy;
                    4: v = hi - hy;
                    5: v = hi - hy + 1;
                    6: v = hi;
                    default: v = hi + 1;
                endcase
            end
            default: v = int'($urandom);
        endcase
        return v;
    endfunction

    // Mostly well-formed traffic on a few busy channels, some pure noise
    function automatic alarm_item_t random_item();
        alarm_item_t it;
        int          pick;
        int          c;
        int          lo;
        it.action = 2'($urandom_range(0, 3));
        it.channel = 4'($urandom_range(0, CHANNELS - 1));
        it.sample = $urandom;
        it.now = {32'($urandom), 32'($urandom)};
        it.lo = $urandom;
        it.hi = $urandom;
        it.hyst = 31'($urandom);
        it.lo_en = 1'($urandom_range(0, 1));
        it.hi_en = 1'($urandom_range(0, 1));
        it.remote = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 8) return it;
        c = focus[$urandom_range(0, 3)];
        advance_wall();
        it.channel = 4'(c);
        it.now = wall_us;
        if (pick < 16) begin
            lo = -int'($urandom_range(0, 40000));
            it.action = ACT_SET;
            it.lo = lo;
            it.hi = lo + int'($urandom_range(0, 80000));
            it.hyst = 31'($urandom_range(0, 2000));
            it.lo_en = ($urandom_range(0, 3) != 0);
            it.hi_en = ($urandom_range(0, 3) != 0);
            it.remote = ($urandom_range(0, 3) == 0);
        end else if (pick < 19) begin
            it.action = ACT_FORGET;
        end else if (pick < 25) begin
            it.action = ACT_QUERY;
        end else begin
            it.action = ACT_SAMPLE;
            it.sample = pick_sample(c);
        end
        return it;
    endfunction

    // Offer one transaction after a random gap and record it once accepted
    task automatic send_item(input alarm_item_t it);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= it.action;
        s_channel <= it.channel;
        s_sample_value <= it.sample;
        s_now_us <= it.now;
        s_low_limit <= it.lo;
        s_high_limit <= it.hi;
        s_hysteresis <= it.hyst;
        s_low_enable <= it.lo_en;
        s_high_enable <= it.hi_en;
        s_remote_low <= it.remote;
        do @(posedge aclk); while (!s_ready);
        sb.predict_alarm(it);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Stop offering and wait until every outstanding result is back, plus the pipeline depth
    task automatic drain_table();
        s_valid <= 1'b0;
        while (sb.alarm_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Result side: random stalls, one long hold-off on request
    initial begin : result_side
        int            stall;
        alarm_result_t got;
        m_ready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_ready <= 1'b0;
                repeat (120) @(posedge aclk);
            end else begin
                stall = calm ? 0 : $urandom_range(0, 3);
                if (stall != 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            got.notify = m_notify;
            got.reminder = m_is_reminder;
            got.chan = m_out_channel;
            got.from_st = m_from_state;
            got.to_st = m_alarm_state;
            got.value = m_report_value;
            sb.check_alarm(got);
        end
    end

    initial begin : stimulus
        logic [31:0] ph_repeat [6];
        logic [3:0]  ph_debounce [6];
        int          p;
        int          k;
        ph_repeat = '{32'd100, 32'd0, 32'hFFFF_FFFF, 32'd250, 32'd1, 32'd1800000000};
        ph_debounce = '{4'd1, 4'd0, 4'd15, 4'd3, 4'd2, 4'd4};
        calm = 1'b0;
        hold_off_req = 1'b0;
        wall_us = '0;
        aresetn <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        s_valid <= 1'b0;
        s_action <= '0;
        s_channel <= '0;
        s_sample_value <= '0;
        s_now_us <= '0;
        s_low_limit <= '0;
        s_high_limit <= '0;
        s_hysteresis <= '0;
        s_low_enable <= 1'b0;
        s_high_enable <= 1'b0;
        s_remote_low <= 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // unused channel: query and forget report nothing
        send_item(plain_item(ACT_QUERY, 4'd3, 32'sd0, 64'd0));
        send_item(plain_item(ACT_FORGET, 4'd3, 32'sd0, 64'd0));
        // a sample opens the channel with the default rule; extremes stay OK
        send_item(plain_item(ACT_SAMPLE, 4'd0, 32'sd0, 64'd10));
        send_item(plain_item(ACT_SAMPLE, 4'd0, 32'sh7FFF_FFFF, 64'd20));
        send_item(plain_item(ACT_SAMPLE, 4'd0, 32'sh8000_0000, 64'd30));
        // set rule re-evaluates the last value at once
        send_item(rule_item(4'd0, -32'sd256, 32'sd256, 31'd64, 1'b1, 1'b1, 1'b0, 64'd40));
        // debounce on the way back to OK, then up to HIGH
        send_item(plain_item(ACT_SAMPLE, 4'd0, 32'sd0, 64'd50));
        send_item(plain_item(ACT_SAMPLE, 4'd0, 32'sd0, 64'd60));
        send_item(plain_item(ACT_SAMPLE, 4'd0, 32'sd1000, 64'd70));
        send_item(plain_item(ACT_SAMPLE, 4'd0, 32'sd1000, 64'd80));
        // reminder after the interval, then with time going backwards
        send_item(plain_item(ACT_SAMPLE, 4'd0, 32'sd1000, 64'd1800000080));
        send_item(plain_item(ACT_SAMPLE, 4'd0, 32'sd1000, 64'd5));
        send_item(plain_item(ACT_QUERY, 4'd0, 32'sd0, 64'd90));
        // extreme rule on an unused channel: nothing to re-evaluate
        send_item(rule_item(4'd1, 32'sh8000_0000, 32'sh7FFF_FFFF, 31'h7FFF_FFFF,
                            1'b1, 1'b1, 1'b1, 64'd0));
        send_item(plain_item(ACT_SAMPLE, 4'd1, 32'sh8000_0000, 64'hFFFF_FFFF_FFFF_FFFF));
        send_item(plain_item(ACT_SAMPLE, 4'd1, 32'sh7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF));
        // remote-low rule mutes the LOW alarm and its reminder
        send_item(rule_item(4'd2, 32'sd0, 32'sd1000, 31'd10, 1'b1, 1'b1, 1'b1, 64'd100));
        send_item(plain_item(ACT_SAMPLE, 4'd2, -32'sd5, 64'd110));
        send_item(plain_item(ACT_SAMPLE, 4'd2, -32'sd5, 64'd120));
        send_item(plain_item(ACT_SAMPLE, 4'd2, -32'sd5, 64'd1800000120));
        // unmuted rule raises LOW at once; a tighter rule keeps channel 0 HIGH
        send_item(rule_item(4'd2, 32'sd0, 32'sd1000, 31'd10, 1'b1, 1'b0, 1'b0, 64'd130));
        send_item(rule_item(4'd0, 32'sd0, 32'sd500, 31'd0, 1'b0, 1'b1, 1'b0, 64'd140));
        // forget a live channel, then look at it again
        send_item(plain_item(ACT_FORGET, 4'd0, 32'sd0, 64'd150));
        send_item(plain_item(ACT_QUERY, 4'd0, 32'sd0, 64'd160));
        send_item(plain_item(ACT_SAMPLE, 4'd15, 32'sd1, 64'd0));

        // random phases, each under its own configuration
        for (p = 0; p < 6; p++) begin
            drain_table();
            write_reg(CFG_REPEAT_INTERVAL, ph_repeat[p]);
            write_reg(CFG_DEBOUNCE_COUNT, {28'd0, ph_debounce[p]});
            calm = (p == 3);
            hold_off_req = (p == 4);
            if (p == 3) wall_us = 64'hFFFF_FFFF_FFFF_F000;
            for (k = 0; k < 4; k++) begin
                focus[k] = $urandom_range(0, CHANNELS - 1);
            end
            for (k = 0; k < 113; k++) begin
                send_item(random_item());
            end
        end
        drain_table();

        if (sb.errors == 0 && sb.alarm_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog: end a hung run
    initial begin
        #1_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
